>>> src/nearest_palette_color_search_defines.svh
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define NPCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define NPCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/npcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package npcs_pkg;

  localparam int unsigned IdxW   = 8;
  localparam int unsigned ColorW = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned DistW  = 10;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  typedef struct packed {
    logic              vld;
    logic [IdxW-1:0]   idx;
    logic [ColorW-1:0] color;
  } npcs_rd_t;

  function automatic logic [ChanW-1:0] chan_diff(input logic [ChanW-1:0] a,
                                                 input logic [ChanW-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

>>> src/nearest_palette_color_search.sv
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_palette_color_search_defines.svh"

// Channel  Dir  tdata (low bit up)                     tuser
// s_axis   in   entry_index[7:0], color[31:8]           command (0 write, 1 map)
// m_axis   out  best_index[7:0], best_color[31:8]       -
//
// A write request gives no result.
// A map request reads the palette memory one entry per cycle in ST_SCAN,
// folds in the last entry in ST_WAIT and loads the output register in ST_DONE.
// Reset clears the palette through per-entry valid bits, with no sweep.
// A result waiting on m_axis holds the next map at its end, not its intake.

module nearest_palette_color_search import npcs_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // entry_index[7:0], color[31:8]
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // best_index[7:0], best_color[31:8]
);

  localparam int unsigned AddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(PALETTE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_d, state_q;
  logic [AddrW-1:0]  addr_d, addr_q;
  logic [ColorW-1:0] pixel_q;
  logic              out_vld_d, out_vld_q;
  logic [IdxW-1:0]   out_idx_q;
  logic [ColorW-1:0] out_color_q;

  logic              req_acc;
  logic [IdxW-1:0]   req_idx;
  logic [ColorW-1:0] req_color;
  logic              wr_en;
  logic              rd_en;
  logic              out_load;
  npcs_rd_t          rd;
  logic [IdxW-1:0]   best_index;
  logic [ColorW-1:0] best_color;

  assign req_idx   = s_axis_tdata[7:0];
  assign req_color = s_axis_tdata[31:8];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign req_acc   = s_axis_tvalid && s_axis_tready;
  assign wr_en     = req_acc && (s_axis_tuser == CMD_WRITE)
                  && ({1'b0, req_idx} < 9'(PALETTE_ENTRIES));
  assign rd_en     = (state_q == ST_SCAN);
  assign out_load  = (state_q == ST_DONE) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    out_vld_d = out_vld_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (req_acc && (s_axis_tuser == CMD_MAP)) begin
          state_d = ST_SCAN;
          addr_d  = '0;
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + AddrW'(1);
        if (addr_q == LastAddr) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      addr_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      pixel_q <= req_color;
    end
    if (out_load) begin
      out_idx_q   <= best_index;
      out_color_q <= best_color;
    end
  end

  npcs_palette #(
    .Entries (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (req_idx[AddrW-1:0]),
    .wr_data_i (req_color),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr_q),
    .rd_o      (rd)
  );

  npcs_scan u_scan (
    .clk_i        (clk_i),
    .pixel_i      (pixel_q),
    .rd_i         (rd),
    .best_index_o (best_index),
    .best_color_o (best_color)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_color_q, out_idx_q};

  `NPCS_ASSERT_NOW(a_wr_only_idle, wr_en, state_q == ST_IDLE, "palette write outside idle")
  `NPCS_ASSERT_NOW(a_rd_after_scan, rd.vld, $past(state_q) == ST_SCAN, "read data without scan")
  `NPCS_ASSERT_NEXT(a_wait_to_done, state_q == ST_WAIT, state_q == ST_DONE, "wait did not finish")
  `NPCS_ASSERT_NOW(a_result_from_done, $rose(m_axis_tvalid), $past(state_q) == ST_DONE,
                   "result raised outside done")

endmodule

`default_nettype wire

>>> src/npcs_palette.sv
`timescale 1ns / 1ps
`default_nettype none

module npcs_palette import npcs_pkg::*; #(
  parameter int unsigned Entries = 256,
  localparam int unsigned AddrW  = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [ColorW-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output npcs_rd_t          rd_o
);

  logic [ColorW-1:0] mem [Entries];
  logic [ColorW-1:0] rdata_q;
  logic [Entries-1:0] vld_q;
  logic               hit_q;
  logic               rvld_q;
  logic [AddrW-1:0]   raddr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      hit_q   <= 1'b0;
      rvld_q  <= 1'b0;
      raddr_q <= '0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rvld_q <= rd_en_i;
      if (rd_en_i) begin
        hit_q   <= vld_q[rd_addr_i];
        raddr_q <= rd_addr_i;
      end
    end
  end

  // unwritten entries read as zero
  always_comb begin
    rd_o.vld   = rvld_q;
    rd_o.idx   = IdxW'(raddr_q);
    rd_o.color = hit_q ? rdata_q : '0;
  end

endmodule

`default_nettype wire

>>> src/npcs_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module npcs_scan import npcs_pkg::*; (
  input  logic              clk_i,
  input  logic [ColorW-1:0] pixel_i,
  input  npcs_rd_t          rd_i,
  output logic [IdxW-1:0]   best_index_o,
  output logic [ColorW-1:0] best_color_o
);

  logic [DistW-1:0]  cand_dist;
  logic              take;
  logic [DistW-1:0]  best_dist_q;
  logic [IdxW-1:0]   best_idx_q;
  logic [ColorW-1:0] best_color_q;

  always_comb begin
    cand_dist = DistW'(chan_diff(pixel_i[7:0],   rd_i.color[7:0]))
              + DistW'(chan_diff(pixel_i[15:8],  rd_i.color[15:8]))
              + DistW'(chan_diff(pixel_i[23:16], rd_i.color[23:16]));
    // entry zero always beats the starting bound
    take = rd_i.vld && ((rd_i.idx == '0) || (cand_dist < best_dist_q));
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dist_q  <= cand_dist;
      best_idx_q   <= rd_i.idx;
      best_color_q <= rd_i.color;
    end
  end

  assign best_index_o = best_idx_q;
  assign best_color_o = best_color_q;

endmodule

`default_nettype wire
